// File: design/tdm_pkg.sv
// Shared constants, codes and types for the transmit descriptor multiplexer.
`default_nettype none
package tdm_pkg;

  // Sizing
  localparam int RING_DEPTH   = 512;
  localparam int BUFFER_BYTES = 2048;
  localparam int CLIENT_COUNT = 3;

  localparam int RING_IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int BUF_SHIFT  = $clog2(BUFFER_BYTES);
  localparam int OFS_HI_W   = 32 - BUF_SHIFT;

  // Field widths
  localparam int OPCODE_W = 2;
  localparam int CLIENT_W = 2;
  localparam int OFFSET_W = 32;
  localparam int LENGTH_W = 16;
  localparam int STATUS_W = 3;
  localparam int ADDR_W   = 64;
  localparam int BUFCNT_W = 10;
  localparam int RING_W   = ADDR_W + LENGTH_W;

  // Configuration port
  localparam int CFG_CLIENTS  = 3;
  localparam int APB_ADDR_W   = 6;
  localparam int APB_DATA_W   = 64;
  localparam int REG_IDX_W    = 3;
  localparam logic [BUFCNT_W-1:0] BUFCNT_RESET = BUFCNT_W'(512);

  localparam logic [REG_IDX_W-1:0] REG_CLIENT0_BASE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CLIENT1_BASE    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CLIENT2_BASE    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CLIENT0_BUFFERS = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CLIENT1_BUFFERS = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CLIENT2_BUFFERS = 3'd5;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_SUBMIT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POP    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ARM    = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_BATCH  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_FORWARDED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTIFY    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NO_NOTIFY = 3'd6;
  localparam logic [STATUS_W-1:0] ST_ARMED     = 3'd7;

  // Client region configuration
  typedef struct packed {
    logic [CFG_CLIENTS-1:0][ADDR_W-1:0]   base;
    logic [CFG_CLIENTS-1:0][BUFCNT_W-1:0] buffers;
  } cfg_t;

  // Advance a ring index modulo the ring depth
  function automatic logic [RING_IDX_W-1:0] ring_next(input logic [RING_IDX_W-1:0] idx);
    logic [RING_IDX_W-1:0] res;
    if (idx == RING_IDX_W'(RING_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + RING_IDX_W'(1);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: design/tdm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tdm_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 512
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic      [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: design/tdm_regs.sv
// APB-style configuration registers for the client regions.
`default_nettype none
module tdm_regs
  import tdm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t                 cfg_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[APB_ADDR_W-1:3];
  assign cfg_o   = cfg_q;

  // Write the addressed register in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_CLIENTS; i++) begin
        cfg_q.base[i]    <= '0;
        cfg_q.buffers[i] <= BUFCNT_RESET;
      end
    end else if (wr_en) begin
      case (reg_idx)
        REG_CLIENT0_BASE:    cfg_q.base[0]    <= pwdata;
        REG_CLIENT1_BASE:    cfg_q.base[1]    <= pwdata;
        REG_CLIENT2_BASE:    cfg_q.base[2]    <= pwdata;
        REG_CLIENT0_BUFFERS: cfg_q.buffers[0] <= pwdata[BUFCNT_W-1:0];
        REG_CLIENT1_BUFFERS: cfg_q.buffers[1] <= pwdata[BUFCNT_W-1:0];
        REG_CLIENT2_BUFFERS: cfg_q.buffers[2] <= pwdata[BUFCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_CLIENT0_BASE:    prdata = cfg_q.base[0];
      REG_CLIENT1_BASE:    prdata = cfg_q.base[1];
      REG_CLIENT2_BASE:    prdata = cfg_q.base[2];
      REG_CLIENT0_BUFFERS: prdata = APB_DATA_W'(cfg_q.buffers[0]);
      REG_CLIENT1_BUFFERS: prdata = APB_DATA_W'(cfg_q.buffers[1]);
      REG_CLIENT2_BUFFERS: prdata = APB_DATA_W'(cfg_q.buffers[2]);
      default:             prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: design/tx_descriptor_multiplexer_top.sv
// Top level of the transmit descriptor multiplexer.
// It takes one transaction per cycle unless the output stalls; one result each, in order.
// Every transaction passes two register stages: the decision stage, where the ring RAM is
// written or read, and then the output register, which drives the output.
// A pop takes its descriptor from the ring RAM's registered read port during the first stage.
// While the output register waits, one more transaction is still accepted into the first stage.
// The ring has no clearing pass after reset: entries are read only after they were written.
// Client regions are set through the APB port at byte address 8*i; the user must set them
// only while idle, and the block itself does not enforce this.
`default_nettype none
module tx_descriptor_multiplexer_top
  import tdm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  // Input channel
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [OPCODE_W-1:0]   opcode_i,
  input  wire logic [CLIENT_W-1:0]   client_i,
  input  wire logic [OFFSET_W-1:0]   offset_i,
  input  wire logic [LENGTH_W-1:0]   length_i,
  // Output channel
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [STATUS_W-1:0]   status_o,
  output logic      [ADDR_W-1:0]     address_o,
  output logic      [LENGTH_W-1:0]   out_length_o,
  output logic      [CLIENT_W-1:0]   out_client_o
);

  cfg_t cfg;

  tdm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Ring pointers and batch flags
  logic [RING_IDX_W-1:0] head_q, head_d, tail_q, tail_d;
  logic                  signalled_q, signalled_d;
  logic                  enq_q, enq_d;

  // Decision stage
  logic                a_valid_q;
  logic [STATUS_W-1:0] a_status_q, a_status_d;
  logic [ADDR_W-1:0]   a_addr_q, a_addr_d;
  logic [LENGTH_W-1:0] a_len_q, a_len_d;
  logic [CLIENT_W-1:0] a_client_q, a_client_d;
  logic                a_from_ram_q, a_from_ram_d;

  // Output register
  logic                b_valid_q;
  logic [STATUS_W-1:0] b_status_q;
  logic [ADDR_W-1:0]   b_addr_q;
  logic [LENGTH_W-1:0] b_len_q;
  logic [CLIENT_W-1:0] b_client_q;

  logic               in_acc, a_to_b, b_free;
  logic               ram_we, ram_re;
  logic [RING_W-1:0]  ram_rdata;

  logic [ADDR_W-1:0]   base_sel;
  logic [BUFCNT_W-1:0] buf_sel;
  logic                client_ok, aligned, in_range;
  logic [ADDR_W-1:0]   phys;
  logic [RING_IDX_W-1:0] tail_nx;
  logic                ring_full, ring_empty;

  // Handshake between stages
  assign b_free     = ~b_valid_q | out_ready_i;
  assign a_to_b     = a_valid_q & b_free;
  assign in_ready_o = ~a_valid_q | b_free;
  assign in_acc     = in_valid_i & in_ready_o;

  // Select the client's region
  always_comb begin
    case (client_i)
      2'd0:    begin base_sel = cfg.base[0]; buf_sel = cfg.buffers[0]; end
      2'd1:    begin base_sel = cfg.base[1]; buf_sel = cfg.buffers[1]; end
      2'd2:    begin base_sel = cfg.base[2]; buf_sel = cfg.buffers[2]; end
      default: begin base_sel = '0;          buf_sel = '0;             end
    endcase
  end

  assign client_ok  = client_i < CLIENT_W'(CLIENT_COUNT);
  assign aligned    = offset_i[BUF_SHIFT-1:0] == '0;
  assign in_range   = offset_i[OFFSET_W-1:BUF_SHIFT] < OFS_HI_W'(buf_sel);
  assign phys       = ADDR_W'(offset_i) + base_sel;
  assign tail_nx    = ring_next(tail_q);
  assign ring_full  = tail_nx == head_q;
  assign ring_empty = head_q == tail_q;

  // Decide the transaction's outcome and the next ring state
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    signalled_d  = signalled_q;
    enq_d        = enq_q;
    a_status_d   = ST_NO_NOTIFY;
    a_addr_d     = '0;
    a_len_d      = '0;
    a_client_d   = '0;
    a_from_ram_d = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    case (opcode_i)
      OP_SUBMIT: begin
        a_len_d    = length_i;
        a_client_d = client_i;
        if (!(client_ok && aligned && in_range)) begin
          a_status_d = ST_REJECTED;
          a_addr_d   = ADDR_W'(offset_i);
        end else if (ring_full) begin
          a_status_d = ST_FULL;
          a_addr_d   = phys;
        end else begin
          a_status_d = ST_FORWARDED;
          a_addr_d   = phys;
          ram_we     = in_acc;
          tail_d     = tail_nx;
          enq_d      = 1'b1;
        end
      end
      OP_POP: begin
        if (ring_empty) begin
          a_status_d = ST_EMPTY;
        end else begin
          a_status_d   = ST_POPPED;
          a_from_ram_d = 1'b1;
          ram_re       = in_acc;
          head_d       = ring_next(head_q);
        end
      end
      OP_ARM: begin
        a_status_d  = ST_ARMED;
        signalled_d = 1'b0;
      end
      default: begin
        if (enq_q && !signalled_q) begin
          a_status_d  = ST_NOTIFY;
          signalled_d = 1'b1;
        end
        enq_d = 1'b0;
      end
    endcase
  end

  tdm_ram #(
    .WIDTH (RING_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i ({phys, length_i}),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // Advance control state on acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      signalled_q <= 1'b0;
      enq_q       <= 1'b0;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        signalled_q <= signalled_d;
        enq_q       <= enq_d;
      end
      if (in_acc) begin
        a_valid_q <= 1'b1;
      end else if (a_to_b) begin
        a_valid_q <= 1'b0;
      end
      if (a_to_b) begin
        b_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  // Hold the decision stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_status_q   <= a_status_d;
      a_addr_q     <= a_addr_d;
      a_len_q      <= a_len_d;
      a_client_q   <= a_client_d;
      a_from_ram_q <= a_from_ram_d;
    end
  end

  // Load the output register, popped descriptors come from the RAM
  always_ff @(posedge clk_i) begin
    if (a_to_b) begin
      b_status_q <= a_status_q;
      b_client_q <= a_client_q;
      if (a_from_ram_q) begin
        b_addr_q <= ram_rdata[RING_W-1:LENGTH_W];
        b_len_q  <= ram_rdata[LENGTH_W-1:0];
      end else begin
        b_addr_q <= a_addr_q;
        b_len_q  <= a_len_q;
      end
    end
  end

  assign out_valid_o  = b_valid_q;
  assign status_o     = b_status_q;
  assign address_o    = b_addr_q;
  assign out_length_o = b_len_q;
  assign out_client_o = b_client_q;

  // A write never fills the last free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ring_next(tail_q) != head_q))
    else $error("ring write with ring full");

  // A pending pop keeps its read data until it moves on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && a_from_ram_q && !a_to_b) |=> $stable(ram_rdata))
    else $error("ring read data changed under a pending pop");

  // Input is refused only when both stages are occupied and the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (a_valid_q && b_valid_q && !out_ready_i))
    else $error("input refused with room in the pipeline");

  // Batch end always clears the enqueue flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == OP_BATCH) |=> !enq_q)
    else $error("enqueue flag survived batch end");

endmodule
`default_nettype wire
